FILE: rtl/acs_pkg.sv
// Shared types and constants for the accelerometer step counter.
// No dependencies; every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps

package acs_pkg;

  localparam int unsigned OP_W     = 16;  // squarer operand and magnitude width
  localparam int unsigned SQ_W     = 32;  // squares and sum of squares
  localparam int unsigned ENERGY_W = 36;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 64;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX  = 36'hF_FFFF_FFFF;
  localparam logic [ENERGY_W-1:0] THRESH_RST  = 36'd20971;
  localparam logic [LIMIT_W-1:0]  HOLDOFF_RST = 8'd7;

  // register select is paddr[3]: 8-byte register slots
  localparam logic REG_THRESH  = 1'b0;
  localparam logic REG_HOLDOFF = 1'b1;

  typedef struct packed {
    logic start;
    logic clear;
  } sqr_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

FILE: rtl/accel_step_counter.sv
// Step counter top: sequencer, window energy, peak/holdoff FSM and APB registers.
// Depends on acs_pkg, acs_sqr, acs_sqrt, acs_ring.
`timescale 1ns / 1ps

// One sample word is processed at a time: the shared bit-serial squarer runs
// for x, y and z, then the serial square root, then the squarer again for the
// squared magnitude difference. Each of these five passes has a start, one bit
// step per operand bit and a done handoff. Then the old square is taken out of
// the window energy and the new one added, and S_EVAL decides the step and
// loads the output register. The next word is taken the cycle after that load,
// even while the result waits, so a new word can be taken before the last
// result is read; a finished result that finds the output register still full
// holds the sequencer and so the input. Ring contents come up as zero after
// reset (per-row valid bits), so no clearing pass is needed. Registers:
// energy_threshold at byte address 0, holdoff_limit at 8 (paddr[3] selects).
module accel_step_counter #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // sample input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [15:0]               accel_x_i,
  input  logic signed [15:0]               accel_y_i,
  input  logic signed [15:0]               accel_z_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [acs_pkg::STEP_W-1:0]       step_total_o,
  output logic [1:0]                       phase_o,
  output logic [acs_pkg::ENERGY_W-1:0]     window_energy_o,
  output logic [acs_pkg::OP_W-1:0]         accel_magnitude_o,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [acs_pkg::APB_AW-1:0]       paddr,
  input  logic [acs_pkg::APB_DW-1:0]       pwdata,
  output logic [acs_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
  // running sum is exact; wide enough for DEPTH full-scale squares and the cap
  localparam int unsigned TOT_W  = (ADDR_W > 4) ? (acs_pkg::SQ_W + ADDR_W) : 37;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DETECT = 2'd1,
    PH_HOLD   = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQZ,
    S_ROOT,
    S_DIFF,
    S_SUB,
    S_EVAL
  } seq_e;

  // ---------------- configuration ----------------
  logic [acs_pkg::ENERGY_W-1:0] thresh_q;
  logic [acs_pkg::LIMIT_W-1:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= acs_pkg::THRESH_RST;
      limit_q  <= acs_pkg::HOLDOFF_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        acs_pkg::REG_THRESH:  thresh_q <= pwdata[acs_pkg::ENERGY_W-1:0];
        acs_pkg::REG_HOLDOFF: limit_q  <= pwdata[acs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      acs_pkg::REG_THRESH:  prdata = acs_pkg::APB_DW'(thresh_q);
      acs_pkg::REG_HOLDOFF: prdata = acs_pkg::APB_DW'(limit_q);
      default:              prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---------------- datapath units ----------------
  seq_e                         seq_q;
  acs_pkg::sqr_ctl_t            sq_ctl_q;
  acs_pkg::unit_st_t            sq_st;
  acs_pkg::unit_st_t            rt_st;
  logic [acs_pkg::OP_W-1:0]     sq_op_q;
  logic [acs_pkg::SQ_W-1:0]     sq_acc;
  logic                         rt_start_q;
  logic [acs_pkg::OP_W-1:0]     root;
  logic                         sq_start;
  logic                         sq_clear;

  logic [ADDR_W-1:0]            idx_q;
  logic [ADDR_W-1:0]            prev_idx;
  logic [ADDR_W-1:0]            next_idx;
  logic [acs_pkg::OP_W-1:0]     prev_mag;
  logic [acs_pkg::OP_W-1:0]     next_mag;
  logic [acs_pkg::SQ_W-1:0]     old_sq;
  logic [acs_pkg::OP_W-1:0]     abs_y_q, abs_z_q, mag_q;
  logic                         accept;

  assign accept   = in_valid_i && in_ready_o;
  assign prev_idx = (idx_q == '0) ? ADDR_W'(WINDOW_DEPTH - 1) : idx_q - ADDR_W'(1);
  assign next_idx = (idx_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : idx_q + ADDR_W'(1);

  // squarer starts on a new word, after x and y, and for the difference;
  // clear only matters together with start
  assign sq_start = ((seq_q == S_IDLE) && in_valid_i) ||
                    (((seq_q == S_SQX) || (seq_q == S_SQY)) && sq_st.done) ||
                    ((seq_q == S_ROOT) && rt_st.done);
  assign sq_clear = (seq_q == S_IDLE) || (seq_q == S_ROOT);

  acs_sqr u_sqr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (sq_ctl_q),
    .operand_i (sq_op_q),
    .st_o      (sq_st),
    .acc_o     (sq_acc)
  );

  acs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rt_start_q),
    .radicand_i (sq_acc),
    .st_o       (rt_st),
    .root_o     (root)
  );

  acs_ring #(
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (seq_q == S_SUB),
    .wr_addr_i   (idx_q),
    .wr_mag_i    (mag_q),
    .wr_sq_i     (sq_acc),
    .rd_en_i     (accept),
    .prev_addr_i (prev_idx),
    .next_addr_i (next_idx),
    .self_addr_i (idx_q),
    .prev_mag_o  (prev_mag),
    .next_mag_o  (next_mag),
    .old_sq_o    (old_sq)
  );

  // ---------------- operand prep ----------------
  logic [15:0] xb, yb, zb;
  logic [acs_pkg::OP_W-1:0] abs_x, abs_y, abs_z;
  logic [acs_pkg::OP_W-1:0] mag_diff;

  assign xb    = accel_x_i;
  assign yb    = accel_y_i;
  assign zb    = accel_z_i;
  // -32768 becomes 32768, still fits unsigned 16 bits
  assign abs_x = xb[15] ? 16'(~xb + 16'd1) : xb;
  assign abs_y = yb[15] ? 16'(~yb + 16'd1) : yb;
  assign abs_z = zb[15] ? 16'(~zb + 16'd1) : zb;
  assign mag_diff = (root >= prev_mag) ? (root - prev_mag) : (prev_mag - root);

  // ---------------- step decision ----------------
  logic [TOT_W-1:0]             tot_q;
  phase_e                       phase_q, phase_n;
  logic [acs_pkg::STEP_W-1:0]   step_q, step_n;
  logic [acs_pkg::LIMIT_W-1:0]  hold_q, hold_n;
  logic [acs_pkg::LIMIT_W:0]    hold_inc;
  logic [acs_pkg::ENERGY_W-1:0] energy;
  logic                         peak;
  logic                         out_free;

  logic                         out_valid_q;
  logic [acs_pkg::STEP_W-1:0]   o_step_q;
  phase_e                       o_phase_q;
  logic [acs_pkg::ENERGY_W-1:0] o_energy_q;
  logic [acs_pkg::OP_W-1:0]     o_mag_q;

  assign energy   = (tot_q > TOT_W'(acs_pkg::ENERGY_MAX)) ? acs_pkg::ENERGY_MAX
                                                          : tot_q[acs_pkg::ENERGY_W-1:0];
  assign peak     = (mag_q > prev_mag) && (mag_q > next_mag);
  assign hold_inc = {1'b0, hold_q} + (acs_pkg::LIMIT_W + 1)'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    step_n  = step_q;
    hold_n  = hold_q;
    phase_n = PH_IDLE;
    unique case (phase_q)
      PH_DETECT: begin
        step_n  = step_q + acs_pkg::STEP_W'(1);
        hold_n  = '0;
        phase_n = PH_HOLD;
      end
      PH_HOLD: begin
        hold_n  = hold_inc[acs_pkg::LIMIT_W-1:0];
        phase_n = (hold_inc > {1'b0, limit_q}) ? PH_IDLE : PH_HOLD;
      end
      default: begin
        phase_n = ((energy > thresh_q) && peak) ? PH_DETECT : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= S_IDLE;
      sq_ctl_q    <= '0;
      rt_start_q  <= 1'b0;
      sq_op_q     <= '0;
      abs_y_q     <= '0;
      abs_z_q     <= '0;
      mag_q       <= '0;
      tot_q       <= '0;
      idx_q       <= '0;
      phase_q     <= PH_IDLE;
      step_q      <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
      o_step_q    <= '0;
      o_phase_q   <= PH_IDLE;
      o_energy_q  <= '0;
      o_mag_q     <= '0;
    end else begin
      sq_ctl_q   <= '{start: sq_start, clear: sq_clear};
      rt_start_q <= (seq_q == S_SQZ) && sq_st.done;
      // in S_EVAL the output register is refilled instead
      if (out_valid_q && out_ready_i && (seq_q != S_EVAL)) begin
        out_valid_q <= 1'b0;
      end
      unique case (seq_q)
        S_IDLE: begin
          if (in_valid_i) begin
            sq_op_q <= abs_x;
            abs_y_q <= abs_y;
            abs_z_q <= abs_z;
            seq_q   <= S_SQX;
          end
        end
        S_SQX: begin
          if (sq_st.done) begin
            sq_op_q <= abs_y_q;
            seq_q   <= S_SQY;
          end
        end
        S_SQY: begin
          if (sq_st.done) begin
            sq_op_q <= abs_z_q;
            seq_q   <= S_SQZ;
          end
        end
        S_SQZ: begin
          if (sq_st.done) begin
            seq_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (rt_st.done) begin
            mag_q   <= root;
            sq_op_q <= mag_diff;
            seq_q   <= S_DIFF;
          end
        end
        S_DIFF: begin
          // drop the square being overwritten, the new one goes in next cycle
          if (sq_st.done) begin
            tot_q <= tot_q - TOT_W'(old_sq);
            seq_q <= S_SUB;
          end
        end
        S_SUB: begin
          tot_q <= tot_q + TOT_W'(sq_acc);
          seq_q <= S_EVAL;
        end
        S_EVAL: begin
          if (out_free) begin
            phase_q     <= phase_n;
            step_q      <= step_n;
            hold_q      <= hold_n;
            idx_q       <= next_idx;
            o_step_q    <= step_n;
            o_phase_q   <= phase_n;
            o_energy_q  <= energy;
            o_mag_q     <= mag_q;
            out_valid_q <= 1'b1;
            seq_q       <= S_IDLE;
          end
        end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (seq_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign step_total_o      = o_step_q;
  assign phase_o           = o_phase_q;
  assign window_energy_o   = o_energy_q;
  assign accel_magnitude_o = o_mag_q;

  // ---------------- assertions ----------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (sq_ctl_q.start && sq_ctl_q.clear))
    else $error("squarer not started on accepted word");

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!sq_st.busy && !rt_st.busy))
    else $error("serial unit busy while taking a new word");

  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sq_st.done && rt_st.done))
    else $error("squarer and root finished together");

  a_step_from_detect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != $past(step_q)) |-> ($past(phase_q) == PH_DETECT))
    else $error("step count moved outside detect");

endmodule

FILE: rtl/acs_sqr.sv
// Bit-serial squarer with accumulate: one multiplier bit per cycle.
// Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_sqr (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  acs_pkg::sqr_ctl_t         ctl_i,
  input  logic [acs_pkg::OP_W-1:0]  operand_i,
  output acs_pkg::unit_st_t         st_o,
  output logic [acs_pkg::SQ_W-1:0]  acc_o
);

  localparam int unsigned CNT_W = $clog2(acs_pkg::OP_W);

  logic [acs_pkg::SQ_W-1:0] mcand_q;
  logic [acs_pkg::OP_W-1:0] mplier_q;
  logic [acs_pkg::SQ_W-1:0] acc_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q;
  logic                     done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !ctl_i.start && busy_q && (cnt_q == CNT_W'(acs_pkg::OP_W - 1));
      if (ctl_i.start) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(acs_pkg::OP_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // acc keeps its value without clear, so several squares add up
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      mcand_q  <= acs_pkg::SQ_W'(operand_i);
      mplier_q <= operand_i;
      if (ctl_i.clear) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign acc_o     = acc_q;

endmodule

FILE: rtl/acs_sqrt.sv
// Digit-serial integer square root: two radicand bits, one root bit per cycle.
// Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [acs_pkg::SQ_W-1:0]  radicand_i,
  output acs_pkg::unit_st_t         st_o,
  output logic [acs_pkg::OP_W-1:0]  root_o
);

  localparam int unsigned RT_W  = acs_pkg::OP_W;
  localparam int unsigned REM_W = RT_W + 2;
  localparam int unsigned CNT_W = $clog2(RT_W);

  logic [acs_pkg::SQ_W-1:0] rad_q;
  logic [REM_W-1:0]         rem_q;
  logic [RT_W-1:0]          root_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     busy_q;
  logic                     done_q;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+2:0] trial;

  assign rem_sh = {rem_q, rad_q[acs_pkg::SQ_W-1 -: 2]};
  assign trial  = {1'b0, rem_sh} - (REM_W + 3)'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(RT_W - 1));
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(RT_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (!trial[REM_W+2]) begin
        rem_q  <= trial[REM_W-1:0];
        root_q <= {root_q[RT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[REM_W-1:0];
        root_q <= {root_q[RT_W-2:0], 1'b0};
      end
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign root_o    = root_q;

endmodule

FILE: rtl/acs_ring.sv
// Magnitude and squared-difference rings with per-row valid bits.
// Unwritten rows read as zero. Depends on acs_pkg.
`timescale 1ns / 1ps

module acs_ring #(
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [acs_pkg::OP_W-1:0]  wr_mag_i,
  input  logic [acs_pkg::SQ_W-1:0]  wr_sq_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             prev_addr_i,
  input  logic [AW-1:0]             next_addr_i,
  input  logic [AW-1:0]             self_addr_i,
  output logic [acs_pkg::OP_W-1:0]  prev_mag_o,
  output logic [acs_pkg::OP_W-1:0]  next_mag_o,
  output logic [acs_pkg::SQ_W-1:0]  old_sq_o
);

  logic [acs_pkg::OP_W-1:0] mag_mem [DEPTH];
  logic [acs_pkg::SQ_W-1:0] sq_mem  [DEPTH];
  logic [DEPTH-1:0]         valid_q;

  logic [acs_pkg::OP_W-1:0] prev_mag_q;
  logic [acs_pkg::OP_W-1:0] next_mag_q;
  logic [acs_pkg::SQ_W-1:0] old_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mag_mem[wr_addr_i] <= wr_mag_i;
      sq_mem[wr_addr_i]  <= wr_sq_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      prev_mag_q <= valid_q[prev_addr_i] ? mag_mem[prev_addr_i] : '0;
      next_mag_q <= valid_q[next_addr_i] ? mag_mem[next_addr_i] : '0;
      old_sq_q   <= valid_q[self_addr_i] ? sq_mem[self_addr_i]  : '0;
    end
  end

  assign prev_mag_o = prev_mag_q;
  assign next_mag_o = next_mag_q;
  assign old_sq_o   = old_sq_q;

endmodule
